FILE: src/stc_pkg.sv
// stc_pkg: constants, word types and step functions shared by the transform
// composition pipeline. No dependencies.
`default_nettype none
package stc_pkg;

  // square root: one result bit per stage, division: one quotient bit per stage
  localparam int RT_STEPS = 32;
  localparam int DV_STEPS = 29;

  // stage indexes in the valid chain
  localparam int ST_DN   = 2 + RT_STEPS;      // division setup
  localparam int ST_UNIT = ST_DN + 1 + DV_STEPS; // unit quaternion components
  localparam int ST_R1   = ST_UNIT + 1;
  localparam int NSTAGE  = ST_R1 + 12;
  localparam int NPASS   = NSTAGE - 2;

  localparam logic [28:0] UNIT_ONE = 29'h1000_0000;

  typedef struct packed {
    logic [2:0][31:0] pt;
    logic [2:0][31:0] v;
    logic [31:0]      ps;
    logic [31:0]      cs;
  } pass_t;

  typedef struct packed {
    logic [1:0][3:0][15:0] mag;
    logic [1:0][3:0]       neg;
    logic [1:0]            zero;
  } qinfo_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] x;
  } rt_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [28:0] nlow;
    logic [28:0] quo;
  } dv_t;

  // one digit of the restoring square root, two radicand bits per step
  function automatic rt_t rt_step(input rt_t a);
    logic [34:0] cur;
    logic [34:0] trial;
    rt_t         b;
    cur   = {a.rem[32:0], a.x[63:62]};
    trial = {1'b0, a.root, 2'b01};
    b.x   = {a.x[61:0], 2'b00};
    if (cur >= trial) begin
      b.rem  = cur - trial;
      b.root = {a.root[30:0], 1'b1};
    end else begin
      b.rem  = cur;
      b.root = {a.root[30:0], 1'b0};
    end
    return b;
  endfunction

  // one bit of restoring long division
  function automatic dv_t dv_step(input dv_t a, input logic [31:0] r);
    logic [32:0] cur;
    logic [32:0] d;
    dv_t         b;
    cur    = {a.rem[31:0], a.nlow[28]};
    d      = {1'b0, r};
    b.nlow = {a.nlow[27:0], 1'b0};
    if (cur >= d) begin
      b.rem = cur - d;
      b.quo = {a.quo[27:0], 1'b1};
    end else begin
      b.rem = cur;
      b.quo = {a.quo[27:0], 1'b0};
    end
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: src/similarity_transform_compose_top.sv
// similarity_transform_compose_top: composes parent and child similarity
// transforms in one pipeline. Depends on stc_pkg.
`default_nettype none
// The block takes one parent/child transform pair per cycle while in_stall is
// low and returns the composed transform of each accepted pair. The pipeline
// runs the quaternion normalization: a 32-stage square root pipeline, one
// root bit per stage, followed by a 29-stage divider, one quotient bit per
// stage, and then twelve stages of multiply, round and saturate. The whole
// pipeline holds while a finished word waits on out_stall, so throughput is
// one word per cycle whenever the consumer takes words. No configuration, no
// state beyond the pipeline, no clearing after reset.
module similarity_transform_compose_top
  import stc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] parent_x,
  input  logic signed [31:0] parent_y,
  input  logic signed [31:0] parent_z,
  input  logic        [63:0] parent_rot,
  input  logic        [31:0] parent_scale,
  input  logic signed [31:0] child_x,
  input  logic signed [31:0] child_y,
  input  logic signed [31:0] child_z,
  input  logic        [63:0] child_rot,
  input  logic        [31:0] child_scale,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic        [63:0] out_rot,
  output logic        [31:0] out_scale
);

  localparam logic signed [61:0] HALF28 = 62'sd134217728;
  localparam logic signed [61:0] HALF42 = 62'sd2199023255552;
  localparam logic signed [65:0] HALF28W = 66'sd134217728;

  logic              en;
  logic [NSTAGE-1:0] vld;

  pass_t  pass_in;
  qinfo_t qi_in;
  pass_t  pass_pipe [NPASS];
  qinfo_t qi_pipe   [ST_UNIT];

  logic [63:0] qword [2];
  logic [15:0] cval;

  logic [31:0] sq   [2][4];
  logic [32:0] ssum [2];
  rt_t         rt   [RT_STEPS][2];
  rt_t         rt_init [2];

  logic [31:0] dn_r [2];
  dv_t         dn   [2][4];
  logic [58:0] nval [2][4];
  logic [31:0] dv_r [DV_STEPS-1][2];
  dv_t         dv   [DV_STEPS][2][4];

  logic signed [29:0] au  [2][4];
  logic [28:0]        qcl [2][4];
  logic signed [29:0] ap1 [4];
  logic signed [29:0] ap2 [4];
  logic signed [29:0] ap3 [4];

  logic signed [61:0] cr  [3][2];
  logic signed [59:0] qp  [4][4];
  logic signed [61:0] dif [3];
  logic signed [61:0] qs  [4];
  logic signed [61:0] dr_c [3];
  logic signed [61:0] tq_c [4];
  logic signed [19:0] rq_c [4];
  logic signed [33:0] p3  [3];
  logic [63:0]        qo  [10];
  logic [63:0]        qo_c;
  logic signed [63:0] tp  [3][3];
  logic signed [65:0] ts  [3];
  logic signed [65:0] tr_c [3];
  logic signed [37:0] rt6 [3];
  logic signed [39:0] rv7 [3];
  logic [39:0]        m8  [3];
  logic [2:0]         neg8, neg9, neg10;
  logic [55:0]        ph9 [3];
  logic [55:0]        pl9 [3];
  logic [63:0]        sp9;
  logic [56:0]        mg10 [3];
  logic [56:0]        plr_c [3];
  logic [64:0]        spr_c;
  logic [31:0]        sc10, sc11, sc12;
  logic [58:0]        o11 [3];
  logic [58:0]        mgs_c [3];
  logic [31:0]        res [3];

  assign en       = ~(vld[NSTAGE-1] & out_stall);
  assign in_stall = vld[NSTAGE-1] & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // input word unpacking
  always_comb begin
    qword[0]      = parent_rot;
    qword[1]      = child_rot;
    pass_in.pt[0] = parent_x;
    pass_in.pt[1] = parent_y;
    pass_in.pt[2] = parent_z;
    pass_in.v[0]  = child_x;
    pass_in.v[1]  = child_y;
    pass_in.v[2]  = child_z;
    pass_in.ps    = parent_scale;
    pass_in.cs    = child_scale;
    cval          = '0;
    for (int q = 0; q < 2; q++) begin
      qi_in.zero[q] = (qword[q] == '0);
      for (int i = 0; i < 4; i++) begin
        cval            = qword[q][16*i +: 16];
        qi_in.neg[q][i] = cval[15];
        qi_in.mag[q][i] = cval[15] ? (~cval + 16'd1) : cval;
      end
    end
  end

  // square root radicand S * 2^30 and division numerators
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      rt_init[q].rem  = '0;
      rt_init[q].root = '0;
      rt_init[q].x    = {1'b0, ssum[q], 30'd0};
      for (int i = 0; i < 4; i++) begin
        nval[q][i] = {qi_pipe[ST_DN-1].mag[q][i], 43'd0}
                   + {28'd0, rt[RT_STEPS-1][q].root[31:1]};
      end
    end
  end

  // quaternion normalization
  always_ff @(posedge clk) begin
    if (en) begin
      pass_pipe[0] <= pass_in;
      qi_pipe[0]   <= qi_in;
      for (int k = 1; k < NPASS; k++) pass_pipe[k] <= pass_pipe[k-1];
      for (int k = 1; k < ST_UNIT; k++) qi_pipe[k] <= qi_pipe[k-1];
      for (int q = 0; q < 2; q++) begin
        for (int i = 0; i < 4; i++) begin
          sq[q][i] <= 32'(qi_in.mag[q][i]) * 32'(qi_in.mag[q][i]);
        end
        ssum[q] <= 33'(sq[q][0]) + 33'(sq[q][1]) + 33'(sq[q][2]) + 33'(sq[q][3]);
        rt[0][q] <= rt_step(rt_init[q]);
        for (int j = 1; j < RT_STEPS; j++) rt[j][q] <= rt_step(rt[j-1][q]);
        dn_r[q]    <= rt[RT_STEPS-1][q].root;
        dv_r[0][q] <= dn_r[q];
        for (int j = 1; j < DV_STEPS-1; j++) dv_r[j][q] <= dv_r[j-1][q];
        for (int i = 0; i < 4; i++) begin
          dn[q][i].rem  <= {3'd0, nval[q][i][58:29]};
          dn[q][i].nlow <= nval[q][i][28:0];
          dn[q][i].quo  <= '0;
          dv[0][q][i]   <= dv_step(dn[q][i], dn_r[q]);
          for (int j = 1; j < DV_STEPS; j++) begin
            dv[j][q][i] <= dv_step(dv[j-1][q][i], dv_r[j-1][q]);
          end
        end
      end
    end
  end

  // clamp and sign of the unit components
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      for (int i = 0; i < 4; i++) begin
        qcl[q][i] = (dv[DV_STEPS-1][q][i].quo > UNIT_ONE) ? UNIT_ONE
                  : dv[DV_STEPS-1][q][i].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < 2; q++) begin
        for (int i = 0; i < 4; i++) begin
          if (qi_pipe[ST_UNIT-1].zero[q]) begin
            au[q][i] <= '0;
          end else if (qi_pipe[ST_UNIT-1].neg[q][i]) begin
            au[q][i] <= -$signed({1'b0, qcl[q][i]});
          end else begin
            au[q][i] <= $signed({1'b0, qcl[q][i]});
          end
        end
      end
    end
  end

  // rounding of the cross products and of the rotation product
  always_comb begin
    qo_c = '0;
    for (int k = 0; k < 3; k++) begin
      dr_c[k] = dif[k] + (dif[k][61] ? (HALF28 - 62'sd1) : HALF28);
      tr_c[k] = ts[k] + (ts[k][65] ? (HALF28W - 66'sd1) : HALF28W);
    end
    for (int k = 0; k < 4; k++) begin
      tq_c[k] = qs[k] + (qs[k][61] ? (HALF42 - 62'sd1) : HALF42);
      rq_c[k] = tq_c[k][61:42];
      if (rq_c[k] > 20'sd32767) begin
        qo_c[16*k +: 16] = 16'h7fff;
      end else if (rq_c[k] < -20'sd32768) begin
        qo_c[16*k +: 16] = 16'h8000;
      end else begin
        qo_c[16*k +: 16] = rq_c[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // first stage: a x v and quaternion partial products
      cr[0][0] <= au[0][1] * $signed(pass_pipe[ST_UNIT].v[2]);
      cr[0][1] <= au[0][2] * $signed(pass_pipe[ST_UNIT].v[1]);
      cr[1][0] <= au[0][2] * $signed(pass_pipe[ST_UNIT].v[0]);
      cr[1][1] <= au[0][0] * $signed(pass_pipe[ST_UNIT].v[2]);
      cr[2][0] <= au[0][0] * $signed(pass_pipe[ST_UNIT].v[1]);
      cr[2][1] <= au[0][1] * $signed(pass_pipe[ST_UNIT].v[0]);
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) qp[i][j] <= au[0][i] * au[1][j];
        ap1[i] <= au[0][i];
        ap2[i] <= ap1[i];
        ap3[i] <= ap2[i];
      end
      // second stage: sums
      for (int k = 0; k < 3; k++) dif[k] <= cr[k][0] - cr[k][1];
      qs[0] <= qp[3][0] + qp[0][3] + qp[1][2] - qp[2][1];
      qs[1] <= qp[3][1] - qp[0][2] + qp[1][3] + qp[2][0];
      qs[2] <= qp[3][2] + qp[0][1] - qp[1][0] + qp[2][3];
      qs[3] <= qp[3][3] - qp[0][0] - qp[1][1] - qp[2][2];
      // third stage: rounding
      for (int k = 0; k < 3; k++) p3[k] <= dr_c[k][61:28];
      qo[0] <= qo_c;
      for (int k = 1; k < 10; k++) qo[k] <= qo[k-1];
      // w*p + a x p
      tp[0][0] <= ap3[3] * p3[0];
      tp[0][1] <= ap3[1] * p3[2];
      tp[0][2] <= ap3[2] * p3[1];
      tp[1][0] <= ap3[3] * p3[1];
      tp[1][1] <= ap3[2] * p3[0];
      tp[1][2] <= ap3[0] * p3[2];
      tp[2][0] <= ap3[3] * p3[2];
      tp[2][1] <= ap3[0] * p3[1];
      tp[2][2] <= ap3[1] * p3[0];
      for (int k = 0; k < 3; k++) begin
        ts[k]  <= tp[k][0] + (tp[k][1] - tp[k][2]);
        rt6[k] <= tr_c[k][65:28];
        rv7[k] <= $signed(pass_pipe[ST_R1+5].v[k]) + $signed({rt6[k], 1'b0});
        neg8[k] <= rv7[k][39];
        m8[k]   <= rv7[k][39] ? (~rv7[k] + 40'd1) : rv7[k];
        ph9[k]  <= m8[k] * pass_pipe[ST_R1+7].ps[31:16];
        pl9[k]  <= m8[k] * pass_pipe[ST_R1+7].ps[15:0];
        mg10[k] <= {1'b0, ph9[k]} + {16'd0, plr_c[k][56:16]};
        o11[k]  <= {{27{pass_pipe[ST_R1+9].pt[k][31]}}, pass_pipe[ST_R1+9].pt[k]}
                 + (neg10[k] ? (~mgs_c[k] + 59'd1) : mgs_c[k]);
        res[k]  <= (!o11[k][58] && o11[k][57:31] != '0) ? 32'h7fff_ffff
                 : (o11[k][58] && o11[k][57:31] != '1) ? 32'h8000_0000
                 : o11[k][31:0];
      end
      neg9  <= neg8;
      neg10 <= neg9;
      sp9   <= 64'(pass_pipe[ST_R1+7].ps) * 64'(pass_pipe[ST_R1+7].cs);
      sc10  <= (spr_c[64:16] > 49'h0_ffff_ffff) ? 32'hffff_ffff : spr_c[47:16];
      sc11  <= sc10;
      sc12  <= sc11;
    end
  end

  always_comb begin
    spr_c = {1'b0, sp9} + 65'h8000;
    for (int k = 0; k < 3; k++) begin
      plr_c[k] = {1'b0, pl9[k]} + 57'h8000;
      mgs_c[k] = {2'b00, mg10[k]};
    end
  end

  assign out_valid = vld[NSTAGE-1];
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign out_rot   = qo[9];
  assign out_scale = sc12;

endmodule
`default_nettype wire
